// ----- hw/rtl/sorted_range_table_macros.svh -----
// ---------------------------------------------------------------------------
// sorted_range_table_macros: assertion helpers
// Shared property forms for the range table checkers.
// ---------------------------------------------------------------------------
`ifndef SORTED_RANGE_TABLE_MACROS_SVH
`define SORTED_RANGE_TABLE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define SRT_ASSERT_IMP(lbl, ant, con) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (con)) \
		else $error("range table check failed");

// next-cycle implication
`define SRT_ASSERT_NXT(lbl, ant, con) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (con)) \
		else $error("range table check failed");

`endif

// ----- hw/rtl/srt_pkg.sv -----
// ---------------------------------------------------------------------------
// srt_pkg
// Types and codes shared by the range table front end, engine and top level.
// ---------------------------------------------------------------------------
package srt_pkg;

	localparam int DEFAULT_DEPTH = 64;

	localparam logic [1:0] KIND_LOOKUP = 2'd0;
	localparam logic [1:0] KIND_INSERT = 2'd1;
	localparam logic [1:0] KIND_REMOVE = 2'd2;

	localparam logic [1:0] ST_DONE      = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;
	localparam logic [1:0] ST_ZERO      = 2'd3;

	typedef enum logic [1:0] {
		OP_LOOKUP,
		OP_INSERT,
		OP_REMOVE,
		OP_NONE
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [31:0] address;
		logic [31:0] length;
		logic [7:0]  region_tag;
	} cmd_t;

	typedef struct packed {
		logic [31:0] rstart;
		logic [31:0] rend;
		logic [7:0]  tag;
	} entry_t;

	// handshake between front queue and engine
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} cmd_chan_t;

endpackage

// ----- hw/rtl/sorted_range_table.sv -----
// ---------------------------------------------------------------------------
// sorted_range_table
// Sorted table of address ranges with lookup, insert and remove.
// ---------------------------------------------------------------------------
//  channel | valid     | stall     | payload
//  in      | in_valid  | in_stall  | kind, address, length, region_tag
//  out     | out_valid | out_stall | status, slot_index, range_start,
//          |           |           | range_end, found_tag, entry_total
//
// sequence from the engine taking a beat to the result register loading:
// lookup: one memory probe per search step, at most ceil(log2(n+1)) probes
// insert, remove: a linear scan compares one entry at a time, then the
//   entries are shifted one at a time; rejected or unknown beats go straight to the result
// a two-beat input queue keeps taking beats while the engine works
// reset empties the table at once by clearing the entry count; no sweep
// a stalled result holds the engine, the queue stalls once it is full
// ---------------------------------------------------------------------------
module sorted_range_table import srt_pkg::*; #(
	parameter int TABLE_DEPTH = DEFAULT_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [31:0] address,
	input  logic [31:0] length,
	input  logic [7:0]  region_tag,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [5:0]  slot_index,
	output logic [31:0] range_start,
	output logic [31:0] range_end,
	output logic [7:0]  found_tag,
	output logic [6:0]  entry_total
);

	cmd_chan_t q_chan;
	logic      q_pop;

	srt_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.kind       (kind),
		.address    (address),
		.length     (length),
		.region_tag (region_tag),
		.q_out      (q_chan),
		.q_pop      (q_pop)
	);

	srt_engine #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_in        (q_chan),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.slot_index  (slot_index),
		.range_start (range_start),
		.range_end   (range_end),
		.found_tag   (found_tag),
		.entry_total (entry_total)
	);

endmodule

// ----- hw/rtl/srt_front.sv -----
// ---------------------------------------------------------------------------
// srt_front
// Accepts input beats, decodes the operation and holds them in a two-entry
// queue for the engine.
// ---------------------------------------------------------------------------
module srt_front import srt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [31:0] address,
	input  logic [31:0] length,
	input  logic [7:0]  region_tag,
	output cmd_chan_t   q_out,
	input  logic        q_pop
);

	cmd_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       push;
	cmd_t       dec;

	assign in_stall = (fill_q == 2'd2);
	assign push     = in_valid && !in_stall;

	always_comb begin
		dec.address    = address;
		dec.length     = length;
		dec.region_tag = region_tag;
		case (kind)
			KIND_LOOKUP: dec.op = OP_LOOKUP;
			KIND_INSERT: dec.op = OP_INSERT;
			KIND_REMOVE: dec.op = OP_REMOVE;
			default:     dec.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !q_pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (!push && q_pop) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

	assign q_out.valid = (fill_q != 2'd0);
	assign q_out.cmd   = slot_q[rd_ptr_q];

endmodule

// ----- hw/rtl/srt_engine.sv -----
// ---------------------------------------------------------------------------
// srt_engine
// Sequencer over the range memory: binary search, linear scans and the
// one-entry-at-a-time shifts of insert and remove, plus the output register.
// ---------------------------------------------------------------------------
module srt_engine import srt_pkg::*; #(
	parameter int TABLE_DEPTH = DEFAULT_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_chan_t   q_in,
	output logic        q_pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [5:0]  slot_index,
	output logic [31:0] range_start,
	output logic [31:0] range_end,
	output logic [7:0]  found_tag,
	output logic [6:0]  entry_total
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
	localparam logic [CW-1:0] ONE_C   = CW'(1);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_LK_CHK = 4'd1;
	localparam logic [3:0] S_LK_CMP = 4'd2;
	localparam logic [3:0] S_SC_CHK = 4'd3;
	localparam logic [3:0] S_SC_CMP = 4'd4;
	localparam logic [3:0] S_SH_CHK = 4'd5;
	localparam logic [3:0] S_SH_WR  = 4'd6;
	localparam logic [3:0] S_INS_WR = 4'd7;
	localparam logic [3:0] S_EMIT   = 4'd8;

	entry_t        mem_q [TABLE_DEPTH];
	entry_t        rdata_q;
	logic [AW-1:0] rd_addr;
	logic          we;
	logic [AW-1:0] wr_addr;
	entry_t        wr_data;

	logic [3:0]    state_q;
	cmd_t          cmd_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] lo_q;
	logic [CW-1:0] hi_q;
	logic [CW-1:0] ptr_q;
	logic [CW-1:0] pos_q;
	logic [1:0]    rstat_q;
	logic [CW-1:0] rslot_q;
	entry_t        rent_q;

	logic [CW:0]   mid_sum;
	logic [CW-1:0] mid;
	logic          is_ins;
	logic          hit;
	logic          load_out;
	entry_t        new_ent;

	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q} - {{CW{1'b0}}, 1'b1};
	assign mid     = mid_sum[CW:1];
	assign is_ins  = (cmd_q.op == OP_INSERT);
	assign hit     = (rdata_q.rstart <= cmd_q.address) && (rdata_q.rend >= cmd_q.address);
	assign load_out = (state_q == S_EMIT) && (!out_valid || !out_stall);
	assign q_pop   = (state_q == S_IDLE) && q_in.valid;

	always_comb begin
		new_ent.rstart = cmd_q.address;
		new_ent.rend   = cmd_q.address + cmd_q.length;
		new_ent.tag    = cmd_q.region_tag;
	end

	always_comb begin
		rd_addr = '0;
		we      = 1'b0;
		wr_addr = pos_q[AW-1:0];
		wr_data = new_ent;
		case (state_q)
			S_LK_CHK: rd_addr = mid[AW-1:0];
			S_SC_CHK: rd_addr = ptr_q[AW-1:0];
			S_SH_CHK: begin
				if (is_ins) begin
					rd_addr = AW'(ptr_q - ONE_C);
				end else begin
					rd_addr = AW'(ptr_q + ONE_C);
				end
			end
			S_SH_WR: begin
				we      = 1'b1;
				wr_addr = ptr_q[AW-1:0];
				wr_data = rdata_q;
			end
			S_INS_WR: we = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wr_addr] <= wr_data;
		end
		rdata_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_in.cmd;
		end
		if (load_out) begin
			status      <= rstat_q;
			slot_index  <= 6'(rslot_q);
			range_start <= rent_q.rstart;
			range_end   <= rent_q.rend;
			found_tag   <= rent_q.tag;
			entry_total <= 7'(count_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			lo_q      <= '0;
			hi_q      <= '0;
			ptr_q     <= '0;
			pos_q     <= '0;
			rstat_q   <= ST_NOT_FOUND;
			rslot_q   <= '0;
			rent_q    <= '0;
			out_valid <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (q_in.valid) begin
						rslot_q <= '0;
						rent_q  <= '0;
						rstat_q <= ST_NOT_FOUND;
						ptr_q   <= '0;
						case (q_in.cmd.op)
							OP_LOOKUP: begin
								lo_q    <= '0;
								hi_q    <= count_q;
								state_q <= S_LK_CHK;
							end
							OP_INSERT: begin
								if (q_in.cmd.address == 32'd0) begin
									rstat_q <= ST_ZERO;
									state_q <= S_EMIT;
								end else if (count_q >= DEPTH_C) begin
									rstat_q <= ST_FULL;
									state_q <= S_EMIT;
								end else begin
									state_q <= S_SC_CHK;
								end
							end
							OP_REMOVE: state_q <= S_SC_CHK;
							default:   state_q <= S_EMIT;
						endcase
					end
				end
				S_LK_CHK: begin
					if (lo_q < hi_q) begin
						ptr_q   <= mid;
						state_q <= S_LK_CMP;
					end else begin
						state_q <= S_EMIT;
					end
				end
				S_LK_CMP: begin
					if (rdata_q.rend < cmd_q.address) begin
						lo_q    <= ptr_q + ONE_C;
						state_q <= S_LK_CHK;
					end else if (rdata_q.rstart > cmd_q.address) begin
						hi_q    <= ptr_q;
						state_q <= S_LK_CHK;
					end else begin
						rstat_q <= ST_DONE;
						rslot_q <= ptr_q;
						rent_q  <= rdata_q;
						state_q <= S_EMIT;
					end
				end
				S_SC_CHK: begin
					if (ptr_q < count_q) begin
						state_q <= S_SC_CMP;
					end else if (is_ins) begin
						// new range goes after every held range
						pos_q   <= ptr_q;
						state_q <= S_SH_CHK;
					end else begin
						state_q <= S_EMIT;
					end
				end
				S_SC_CMP: begin
					if (is_ins) begin
						if (rdata_q.rstart < cmd_q.address) begin
							ptr_q   <= ptr_q + ONE_C;
							state_q <= S_SC_CHK;
						end else begin
							pos_q   <= ptr_q;
							ptr_q   <= count_q;
							state_q <= S_SH_CHK;
						end
					end else if (hit) begin
						pos_q   <= ptr_q;
						rent_q  <= rdata_q;
						state_q <= S_SH_CHK;
					end else begin
						ptr_q   <= ptr_q + ONE_C;
						state_q <= S_SC_CHK;
					end
				end
				S_SH_CHK: begin
					if (is_ins) begin
						state_q <= (ptr_q > pos_q) ? S_SH_WR : S_INS_WR;
					end else if (ptr_q + ONE_C < count_q) begin
						state_q <= S_SH_WR;
					end else begin
						count_q <= count_q - ONE_C;
						rstat_q <= ST_DONE;
						rslot_q <= pos_q;
						state_q <= S_EMIT;
					end
				end
				S_SH_WR: begin
					ptr_q   <= is_ins ? ptr_q - ONE_C : ptr_q + ONE_C;
					state_q <= S_SH_CHK;
				end
				S_INS_WR: begin
					count_q <= count_q + ONE_C;
					rstat_q <= ST_DONE;
					rslot_q <= pos_q;
					rent_q  <= new_ent;
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- hw/rtl/srt_checker.sv -----
// ---------------------------------------------------------------------------
// srt_checker
// Port-level checks on the range table results.
// ---------------------------------------------------------------------------
`include "sorted_range_table_macros.svh"

module srt_checker import srt_pkg::*; #(
	parameter int TABLE_DEPTH = DEFAULT_DEPTH
) (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  status,
	input logic [5:0]  slot_index,
	input logic [31:0] range_start,
	input logic [31:0] range_end,
	input logic [7:0]  found_tag,
	input logic [6:0]  entry_total
);

	localparam logic [6:0] TOTAL_MAX = 7'(TABLE_DEPTH);

	// a beat held by stall stays offered
	`SRT_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid)
	// failed operations report no range
	`SRT_ASSERT_IMP(a_fail_zero, out_valid && status != ST_DONE, slot_index == 6'd0 && range_start == 32'd0 && range_end == 32'd0 && found_tag == 8'd0)
	// a zero start is never stored, so a reported range never starts at zero
	`SRT_ASSERT_IMP(a_done_start, out_valid && status == ST_DONE, range_start != 32'd0)
	// a full report comes only with a full table
	`SRT_ASSERT_IMP(a_full_total, out_valid && status == ST_FULL, entry_total == TOTAL_MAX)

endmodule

bind sorted_range_table srt_checker #(
	.TABLE_DEPTH (TABLE_DEPTH)
) u_srt_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.status      (status),
	.slot_index  (slot_index),
	.range_start (range_start),
	.range_end   (range_end),
	.found_tag   (found_tag),
	.entry_total (entry_total)
);

// ----- tb/tb_sorted_range_table.sv -----
// ---------------------------------------------------------------------------
// tb_sorted_range_table
// Drives lookup, insert, remove and unknown-kind beats into the range table with random
// gaps and output stalls, predicts answers from a local copy of the sorted
// table or the typed rows and checks each result field by field, in order.
// ---------------------------------------------------------------------------
module tb_sorted_range_table;
	import srt_pkg::*;

	localparam int DEPTH      = DEFAULT_DEPTH;
	localparam int N_RANDOM   = 1930;
	localparam int CYCLE_MAX  = 1500000;
	localparam int TAIL_WAIT  = 400;
	localparam logic [1:0] KIND_NONE = 2'(OP_NONE);

	typedef struct packed {
		logic [1:0]  status;
		logic [5:0]  slot;
		logic [31:0] rstart;
		logic [31:0] rend;
		logic [7:0]  tag;
		logic [6:0]  total;
	} answer_t;

	typedef struct packed {
		logic [1:0]  k;
		logic [31:0] addr;
		logic [31:0] len;
		logic [7:0]  tag;
		logic        typed;
		answer_t     ans;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  kind;
	logic [31:0] address;
	logic [31:0] length;
	logic [7:0]  region_tag;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  status;
	logic [5:0]  slot_index;
	logic [31:0] range_start;
	logic [31:0] range_end;
	logic [7:0]  found_tag;
	logic [6:0]  entry_total;

	// local copy of the table
	logic [31:0] tab_start [DEPTH];
	logic [31:0] tab_end   [DEPTH];
	logic [7:0]  tab_tag   [DEPTH];
	int          tab_count;

	answer_t pending_answers[$];
	int      n_errors;
	int      n_answers;
	int      n_cycles;
	bit      tx_quiet;
	bit      rx_quiet;

	sorted_range_table u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.kind(kind), .address(address), .length(length), .region_tag(region_tag),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .slot_index(slot_index), .range_start(range_start),
		.range_end(range_end), .found_tag(found_tag), .entry_total(entry_total)
	);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	function automatic answer_t slot_answer(logic [1:0] st, int s);
		answer_t a;
		a.status = st;
		a.slot   = 6'(s);
		a.rstart = tab_start[s];
		a.rend   = tab_end[s];
		a.tag    = tab_tag[s];
		a.total  = 7'(tab_count);
		return a;
	endfunction

	function automatic answer_t miss_answer(logic [1:0] st);
		answer_t a;
		a = '0;
		a.status = st;
		a.total  = 7'(tab_count);
		return a;
	endfunction

	function automatic answer_t table_op(logic [1:0] k, logic [31:0] addr,
			logic [31:0] len, logic [7:0] tag);
		int first;
		int last;
		int mid;
		int pos;
		answer_t a;
		if (k == KIND_LOOKUP) begin
			first = 0;
			last  = tab_count - 1;
			while (first <= last) begin
				mid = (first + last) / 2;
				if (tab_end[mid] < addr) first = mid + 1;
				else if (tab_start[mid] > addr) last = mid - 1;
				else return slot_answer(ST_DONE, mid);
			end
			return miss_answer(ST_NOT_FOUND);
		end
		if (k == KIND_INSERT) begin
			if (addr == 0) return miss_answer(ST_ZERO);
			if (tab_count >= DEPTH) return miss_answer(ST_FULL);
			pos = 0;
			while (pos < tab_count && tab_start[pos] < addr) pos++;
			for (int i = tab_count; i > pos; i--) begin
				tab_start[i] = tab_start[i-1];
				tab_end[i]   = tab_end[i-1];
				tab_tag[i]   = tab_tag[i-1];
			end
			tab_start[pos] = addr;
			tab_end[pos]   = addr + len;
			tab_tag[pos]   = tag;
			tab_count++;
			return slot_answer(ST_DONE, pos);
		end
		if (k == KIND_REMOVE) begin
			for (int i = 0; i < tab_count; i++) begin
				if (tab_start[i] <= addr && tab_end[i] >= addr) begin
					a = slot_answer(ST_DONE, i);
					for (int j = i; j + 1 < tab_count; j++) begin
						tab_start[j] = tab_start[j+1];
						tab_end[j]   = tab_end[j+1];
						tab_tag[j]   = tab_tag[j+1];
					end
					tab_count--;
					tab_start[tab_count] = 32'd0;
					tab_end[tab_count]   = 32'd0;
					tab_tag[tab_count]   = 8'd0;
					a.total = 7'(tab_count);
					return a;
				end
			end
		end
		return miss_answer(ST_NOT_FOUND);
	endfunction

	// address inside a held range (its start if the end wraps), or a random one on an empty table
	function automatic logic [31:0] held_address();
		int s;
		if (tab_count == 0) return $urandom;
		s = $urandom_range(0, tab_count - 1);
		if (tab_end[s] < tab_start[s]) return tab_start[s];
		return tab_start[s] + $urandom_range(0, tab_end[s] - tab_start[s]);
	endfunction

	task automatic send_beat(dir_row_t b);
		int gap;
		answer_t a;
		gap = tx_quiet ? 0 : $urandom_range(0, 14);
		repeat (gap) begin
			@(negedge clk);
			in_valid = 0;
		end
		@(negedge clk);
		in_valid   = 1;
		kind       = b.k;
		address    = b.addr;
		length     = b.len;
		region_tag = b.tag;
		do @(posedge clk); while (in_stall);
		a = table_op(b.k, b.addr, b.len, b.tag);
		pending_answers.push_back(b.typed ? b.ans : a);
	endtask

	// result side
	initial begin
		int hold;
		answer_t e;
		answer_t got;
		hold = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				got = '{status, slot_index, range_start, range_end, found_tag, entry_total};
				if (pending_answers.size() == 0) begin
					$display("%0t: unexpected result beat %h", $time, got);
					n_errors++;
				end else begin
					e = pending_answers.pop_front();
					if (got !== e) begin
						$display("%0t: mismatch expected st=%0d slot=%0d start=%h end=%h tag=%h total=%0d",
							$time, e.status, e.slot, e.rstart, e.rend, e.tag, e.total);
						$display("%0t:          actual   st=%0d slot=%0d start=%h end=%h tag=%h total=%0d",
							$time, got.status, got.slot, got.rstart, got.rend, got.tag, got.total);
						n_errors++;
					end
				end
				n_answers++;
				if (n_answers % 64 == 0) rx_quiet = ($urandom_range(0, 3) == 0);
				// long hold so the input queue backs up
				if (n_answers == 300) hold = 400;
				else hold = rx_quiet ? 0 : $urandom_range(0, 14);
			end
			@(negedge clk);
			if (hold > 0) begin
				out_stall = 1;
				hold--;
			end else begin
				out_stall = 0;
			end
		end
	end

	always @(posedge clk) begin
		n_cycles++;
		if (n_cycles > CYCLE_MAX) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		dir_row_t dir_tab [20];
		dir_row_t b;
		int r;
		bit filling;
		arst_n = 0;
		in_valid = 0;
		kind = KIND_LOOKUP;
		address = 0;
		length = 0;
		region_tag = 0;
		out_stall = 0;
		n_errors = 0;
		n_answers = 0;
		n_cycles = 0;
		tx_quiet = 0;
		rx_quiet = 0;
		tab_count = 0;
		for (int i = 0; i < DEPTH; i++) begin
			tab_start[i] = 32'd0;
			tab_end[i]   = 32'd0;
			tab_tag[i]   = 8'd0;
		end

		dir_tab[0]  = '{KIND_LOOKUP, 32'h0, 32'h0, 8'h00, 1'b1,
			'{ST_NOT_FOUND, 6'd0, 32'h0, 32'h0, 8'h00, 7'd0}};
		dir_tab[1]  = '{KIND_REMOVE, 32'h5, 32'h0, 8'h00, 1'b1,
			'{ST_NOT_FOUND, 6'd0, 32'h0, 32'h0, 8'h00, 7'd0}};
		dir_tab[2]  = '{KIND_INSERT, 32'h0, 32'h10, 8'h11, 1'b1,
			'{ST_ZERO, 6'd0, 32'h0, 32'h0, 8'h00, 7'd0}};
		dir_tab[3]  = '{KIND_NONE, 32'h100, 32'h0, 8'h00, 1'b1,
			'{ST_NOT_FOUND, 6'd0, 32'h0, 32'h0, 8'h00, 7'd0}};
		dir_tab[4]  = '{KIND_INSERT, 32'h100, 32'hff, 8'hff, 1'b1,
			'{ST_DONE, 6'd0, 32'h100, 32'h1ff, 8'hff, 7'd1}};
		// end wraps past the top of the address space
		dir_tab[5]  = '{KIND_INSERT, 32'hffffffff, 32'hffffffff, 8'h00, 1'b0, '0};
		dir_tab[6]  = '{KIND_INSERT, 32'h80000000, 32'h0, 8'ha5, 1'b0, '0};
		dir_tab[7]  = '{KIND_INSERT, 32'h100, 32'h10, 8'h01, 1'b0, '0};
		dir_tab[8]  = '{KIND_INSERT, 32'h1, 32'hffffffff, 8'h5a, 1'b0, '0};
		dir_tab[9]  = '{KIND_LOOKUP, 32'h100, 32'h0, 8'h00, 1'b0, '0};
		dir_tab[10] = '{KIND_LOOKUP, 32'h1ff, 32'h0, 8'h00, 1'b0, '0};
		dir_tab[11] = '{KIND_LOOKUP, 32'hffffffff, 32'h0, 8'h00, 1'b0, '0};
		dir_tab[12] = '{KIND_LOOKUP, 32'h80000000, 32'h0, 8'h00, 1'b0, '0};
		dir_tab[13] = '{KIND_LOOKUP, 32'h0, 32'h0, 8'h00, 1'b0, '0};
		dir_tab[14] = '{KIND_LOOKUP, 32'h7fffffff, 32'h0, 8'h00, 1'b0, '0};
		dir_tab[15] = '{KIND_REMOVE, 32'h105, 32'h0, 8'h00, 1'b0, '0};
		dir_tab[16] = '{KIND_REMOVE, 32'hffffffff, 32'h0, 8'h00, 1'b0, '0};
		dir_tab[17] = '{KIND_REMOVE, 32'h12345, 32'h0, 8'h00, 1'b0, '0};
		dir_tab[18] = '{KIND_INSERT, 32'h0, 32'hffffffff, 8'hff, 1'b0, '0};
		dir_tab[19] = '{KIND_NONE, 32'hffffffff, 32'hffffffff, 8'hff, 1'b0, '0};

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		foreach (dir_tab[i]) send_beat(dir_tab[i]);

		for (int i = 0; i < N_RANDOM; i++) begin
			if (i % 50 == 0) tx_quiet = ($urandom_range(0, 3) == 0);
			// let everything drain once, then carry on
			if (i == 1000) begin
				@(negedge clk);
				in_valid = 0;
				while (pending_answers.size() != 0) @(posedge clk);
			end
			filling = ((i / 120) % 2 == 0);
			b = '0;
			b.tag = 8'($urandom);
			r = $urandom_range(0, 99);
			if (r < 5) begin
				// noise: unknown kind, zero start, or random probes
				b.k    = 2'($urandom);
				b.addr = ($urandom_range(0, 1) == 0) ? 32'h0 : $urandom;
				b.len  = $urandom;
			end else if (r < (filling ? 75 : 20)) begin
				b.k = KIND_INSERT;
				if ($urandom_range(0, 1) == 0) begin
					b.addr = $urandom_range(1, 4096);
					b.len  = $urandom_range(0, 300);
				end else begin
					b.addr = $urandom;
					b.len  = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 65535);
				end
			end else if (r < (filling ? 88 : 60)) begin
				b.k    = KIND_LOOKUP;
				b.addr = ($urandom_range(0, 5) == 0) ? $urandom : held_address();
			end else begin
				b.k    = KIND_REMOVE;
				b.addr = ($urandom_range(0, 5) == 0) ? $urandom : held_address();
			end
			send_beat(b);
		end
		@(negedge clk);
		in_valid = 0;

		while (pending_answers.size() != 0) @(posedge clk);
		repeat (TAIL_WAIT) @(posedge clk);
		if (n_errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
